>>> src/iorr_pkg.sv
// iorr_pkg: shared types and constants for the isotp/obd response reassembler
// no dependencies; used by the channel index and top level modules of the block and by its checkers
package iorr_pkg;

    localparam int ID_W = 11;

    typedef struct packed {
        logic [10:0] can_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } frame_t;

    typedef struct packed {
        logic        kind;
        logic [10:0] target_id;
        logic [5:0]  mode;
        logic [7:0]  pid;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic [6:0]  msg_length;
        logic        last;
    } result_t;

    // result kinds
    localparam logic KIND_FLOW = 1'b0;
    localparam logic KIND_MSG  = 1'b1;

    // protocol control info frame types (upper nibble of byte0)
    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    // diagnostic response id window 0x700-0x7ff
    localparam logic [2:0]  OBD_ID_HI    = 3'h7;
    localparam logic [10:0] FC_ID_OFFSET = 11'd8;

    // mode and pid bytes are counted in the length field
    localparam logic [11:0] HDR_BYTES  = 12'd2;
    localparam logic [11:0] FF_MIN_RAW = 12'd7;
    localparam logic [2:0]  SF_HDR     = 3'd2;

    localparam logic [2:0] FF_LAST_CNT = 3'd3;
    localparam int         FF_BYTES    = 4;
    localparam logic [2:0] CF_BYTES    = 3'd7;
    localparam logic [3:0] SEQ_FIRST   = 4'd1;

endpackage

>>> src/iorr_ram.sv
// iorr_ram: simple dual-port synchronous ram, one write and one registered read port
// no dependencies; holds the per-channel entry records and the message bytes
module iorr_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/iorr_chan_mod.sv
// iorr_chan_mod: channel index as can_id modulo CHANNELS by reciprocal multiplication
// two registered steps, quotient then remainder; depends on iorr_pkg for the id width
module iorr_chan_mod #(
    parameter int CHANNELS = 8,
    parameter int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [iorr_pkg::ID_W-1:0] id,
    output logic                      done,
    output logic [CH_W-1:0]           ch
);

    localparam int ID_W = iorr_pkg::ID_W;
    localparam int SH   = ID_W + $clog2(CHANNELS);
    localparam int M_W  = ID_W + 2;
    localparam int P_W  = ID_W + M_W;
    localparam int QD_W = ID_W + 9;
    // ceil(2**SH / CHANNELS) gives the exact quotient for every id value
    localparam logic [M_W-1:0]  RECIP   =
        M_W'(((64'd1 << SH) + 64'(CHANNELS) - 64'd1) / 64'(CHANNELS));
    localparam logic [QD_W-1:0] DIVISOR = QD_W'(CHANNELS);

    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] quo_reg, quo_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [P_W-1:0]  prod;
    logic [QD_W-1:0] quo_mul;
    logic [ID_W-1:0] rem;

    assign prod    = P_W'(id) * P_W'(RECIP);
    assign quo_mul = QD_W'(quo_reg) * DIVISOR;
    assign rem     = id_reg - quo_mul[ID_W-1:0];

    always_comb
    begin
        id_next   = id_reg;
        quo_next  = quo_reg;
        ch_next   = ch_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            id_next   = id;
            quo_next  = ID_W'(prod >> SH);
            busy_next = 1'b1;
        end
        if (busy_reg)
        begin
            ch_next   = rem[CH_W-1:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg   <= '0;
            quo_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ch_reg   <= '0;
        end
        else
        begin
            id_reg   <= id_next;
            quo_reg  <= quo_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            ch_reg   <= ch_next;
        end
    end

    assign done = done_reg;
    assign ch   = ch_reg;

endmodule

>>> src/isotp_obd_response_reassembler.sv
// isotp_obd_response_reassembler: top level, frame decode fsm around two rams; uses iorr_pkg
// steps: channel lookup, then single frame 1 beat/cycle unless result_stall holds it, first frame 4 ram
// writes + flow control beat, consecutive frame 1 meta read + up to 7 byte writes
// a completed message drains 1 byte/cycle from the byte ram (registered read) unless result_stall holds it
// one frame in work at a time
// reset clears the fsm registers and the entry valid bits; ram contents are not cleared
module isotp_obd_response_reassembler #(
    parameter int CHANNELS  = 8,
    parameter int MSG_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  iorr_pkg::frame_t  frame,
    output logic              result_valid,
    input  logic              result_stall,
    output iorr_pkg::result_t result
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W = $clog2(MSG_BYTES);
    localparam int LEN_W = $clog2(MSG_BYTES + 1);
    localparam int SA_W  = CH_W + IDX_W;
    localparam logic [12:0] FF_MAX_RAW = 13'(MSG_BYTES + 2);

    typedef struct packed {
        logic [10:0]      tag;
        logic [3:0]       seq;
        logic [LEN_W-1:0] exp_len;
        logic [LEN_W-1:0] rcv_len;
        logic [4:0]       mode;
        logic [7:0]       pid;
    } meta_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_SINGLE,
        S_FIRST,
        S_FC,
        S_META,
        S_APPEND,
        S_DRAIN
    } state_t;

    state_t             state_reg, state_next;
    iorr_pkg::frame_t   frame_reg, frame_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [2:0]         n_reg, n_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   rcv_reg, rcv_next;
    logic [LEN_W-1:0]   end_reg, end_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic [4:0]         emode_reg, emode_next;
    logic [7:0]         epid_reg, epid_next;
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic                out_valid_reg, out_valid_next;
    iorr_pkg::result_t   out_reg, out_next;

    logic             mod_start, mod_done;
    logic [CH_W-1:0]  mod_ch;

    logic             meta_we, meta_re;
    logic [CH_W-1:0]  meta_raddr;
    meta_t            meta_wdata, meta_rdata;

    logic             st_we, st_re;
    logic [SA_W-1:0]  st_waddr, st_raddr;
    logic [7:0]       st_wdata, st_rdata;

    // frame decode
    logic [3:0]       ftype;
    logic             id_ok;
    logic [11:0]      ff_raw;
    logic             ff_ok;
    logic [2:0]       sf_len;
    logic [2:0]       sf_n;
    logic [LEN_W-1:0] rem_len;
    logic [2:0]       cf_n;
    logic             can_load;
    logic             sf_last;
    logic             dr_last;
    logic [7:0]       sf_byte, ff_byte, cf_byte;

    assign mod_start = frame_valid && (state_reg == S_IDLE);

    iorr_chan_mod #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_chan_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .id    (frame.can_id),
        .done  (mod_done),
        .ch    (mod_ch)
    );

    iorr_ram #(
        .DW ($bits(meta_t)),
        .AW (CH_W)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (ch_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    iorr_ram #(
        .DW (8),
        .AW (SA_W)
    ) u_byte_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign ftype  = frame_reg.byte0[7:4];
    assign id_ok  = (frame_reg.can_id[10:8] == iorr_pkg::OBD_ID_HI);
    assign ff_raw = {frame_reg.byte0[3:0], frame_reg.byte1};
    assign ff_ok  = (ff_raw >= iorr_pkg::FF_MIN_RAW) && (13'(ff_raw) <= FF_MAX_RAW);
    assign sf_len = frame_reg.byte0[2:0];
    assign sf_n   = (sf_len > iorr_pkg::SF_HDR) ? (sf_len - iorr_pkg::SF_HDR) : 3'd0;
    assign rem_len = meta_rdata.exp_len - meta_rdata.rcv_len;
    assign cf_n   = (rem_len > LEN_W'(iorr_pkg::CF_BYTES)) ? iorr_pkg::CF_BYTES
                                                           : rem_len[2:0];
    assign can_load = !out_valid_reg || !result_stall;
    assign sf_last  = (n_reg == 3'd0) || (cnt_reg == (n_reg - 3'd1));
    assign dr_last  = (idx_reg == (total_reg - 1'b1));

    always_comb
    begin
        case (cnt_reg)
            3'd0:    sf_byte = frame_reg.byte3;
            3'd1:    sf_byte = frame_reg.byte4;
            3'd2:    sf_byte = frame_reg.byte5;
            3'd3:    sf_byte = frame_reg.byte6;
            default: sf_byte = frame_reg.byte7;
        endcase
        case (cnt_reg[1:0])
            2'd0:    ff_byte = frame_reg.byte4;
            2'd1:    ff_byte = frame_reg.byte5;
            2'd2:    ff_byte = frame_reg.byte6;
            default: ff_byte = frame_reg.byte7;
        endcase
        case (cnt_reg)
            3'd0:    cf_byte = frame_reg.byte1;
            3'd1:    cf_byte = frame_reg.byte2;
            3'd2:    cf_byte = frame_reg.byte3;
            3'd3:    cf_byte = frame_reg.byte4;
            3'd4:    cf_byte = frame_reg.byte5;
            3'd5:    cf_byte = frame_reg.byte6;
            default: cf_byte = frame_reg.byte7;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        frame_next = frame_reg;
        ch_next    = ch_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        rcv_next   = rcv_reg;
        end_next   = end_reg;
        total_next = total_reg;
        emode_next = emode_reg;
        epid_next  = epid_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        meta_we    = 1'b0;
        meta_re    = 1'b0;
        meta_raddr = mod_ch;
        meta_wdata = meta_rdata;
        st_we      = 1'b0;
        st_re      = 1'b0;
        st_waddr   = '0;
        st_wdata   = '0;
        st_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    frame_next = frame;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    ch_next    = mod_ch;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = S_IDLE;
                    if (id_ok)
                    begin
                        case (ftype)
                            iorr_pkg::FT_SINGLE:
                            begin
                                n_next = sf_n;
                                if (frame_reg.byte1[6])
                                begin
                                    state_next = S_SINGLE;
                                end
                            end
                            iorr_pkg::FT_FIRST:
                            begin
                                if (ff_ok)
                                begin
                                    state_next = S_FIRST;
                                end
                            end
                            iorr_pkg::FT_CONSEC:
                            begin
                                if (valid_reg[mod_ch])
                                begin
                                    meta_re    = 1'b1;
                                    state_next = S_META;
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_SINGLE:
            begin
                if (can_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.kind         = iorr_pkg::KIND_MSG;
                    out_next.target_id    = frame_reg.can_id;
                    out_next.mode         = frame_reg.byte1[5:0];
                    out_next.pid          = frame_reg.byte2;
                    out_next.data_byte    = (n_reg == 3'd0) ? 8'd0 : sf_byte;
                    out_next.byte_index   = 6'(cnt_reg);
                    out_next.msg_length   = 7'(n_reg);
                    out_next.last         = sf_last;
                    cnt_next              = cnt_reg + 3'd1;
                    if (sf_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_FIRST:
            begin
                st_we    = 1'b1;
                st_waddr = {ch_reg, IDX_W'(cnt_reg)};
                st_wdata = ff_byte;
                // the entry record goes in with the first byte write
                if (cnt_reg == 3'd0)
                begin
                    meta_we            = 1'b1;
                    meta_wdata.tag     = frame_reg.can_id;
                    meta_wdata.seq     = iorr_pkg::SEQ_FIRST;
                    meta_wdata.exp_len = LEN_W'(ff_raw - iorr_pkg::HDR_BYTES);
                    meta_wdata.rcv_len = LEN_W'(iorr_pkg::FF_BYTES);
                    meta_wdata.mode    = frame_reg.byte2[4:0];
                    meta_wdata.pid     = frame_reg.byte3;
                    valid_next[ch_reg] = 1'b1;
                end
                if (cnt_reg == iorr_pkg::FF_LAST_CNT)
                begin
                    state_next = S_FC;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            S_FC:
            begin
                if (can_load)
                begin
                    out_valid_next      = 1'b1;
                    out_next            = '0;
                    out_next.kind       = iorr_pkg::KIND_FLOW;
                    out_next.target_id  = frame_reg.can_id - iorr_pkg::FC_ID_OFFSET;
                    out_next.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_META:
            begin
                state_next = S_IDLE;
                if ((meta_rdata.tag == frame_reg.can_id) &&
                    (meta_rdata.seq == frame_reg.byte0[3:0]))
                begin
                    meta_we            = 1'b1;
                    meta_wdata.seq     = meta_rdata.seq + 4'd1;
                    meta_wdata.rcv_len = meta_rdata.rcv_len + LEN_W'(cf_n);
                    rcv_next   = meta_rdata.rcv_len;
                    end_next   = meta_rdata.rcv_len + LEN_W'(cf_n);
                    total_next = meta_rdata.exp_len;
                    emode_next = meta_rdata.mode;
                    epid_next  = meta_rdata.pid;
                    n_next     = cf_n;
                    cnt_next   = '0;
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                if (cnt_reg < n_reg)
                begin
                    st_we    = 1'b1;
                    st_waddr = {ch_reg, IDX_W'(rcv_reg + LEN_W'(cnt_reg))};
                    st_wdata = cf_byte;
                    cnt_next = cnt_reg + 3'd1;
                end
                else if (end_reg == total_reg)
                begin
                    // message complete: free the entry and start the drain
                    valid_next[ch_reg] = 1'b0;
                    st_re      = 1'b1;
                    st_raddr   = {ch_reg, IDX_W'(0)};
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                // read data for idx_reg is held until it is loaded
                if (can_load)
                begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = iorr_pkg::KIND_MSG;
                    out_next.target_id  = frame_reg.can_id;
                    out_next.mode       = {1'b0, emode_reg};
                    out_next.pid        = epid_reg;
                    out_next.data_byte  = st_rdata;
                    out_next.byte_index = 6'(idx_reg);
                    out_next.msg_length = 7'(total_reg);
                    out_next.last       = dr_last;
                    if (dr_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        st_re    = 1'b1;
                        st_raddr = {ch_reg, IDX_W'(idx_reg + 1'b1)};
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frame_reg     <= '0;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            rcv_reg       <= '0;
            end_reg       <= '0;
            total_reg     <= '0;
            emode_reg     <= '0;
            epid_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            rcv_reg       <= rcv_next;
            end_reg       <= end_next;
            total_reg     <= total_next;
            emode_reg     <= emode_next;
            epid_reg      <= epid_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign frame_stall  = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

>>> src/iorr_checker.sv
// iorr_checker: port-level checks on the reassembler's frame and result channels
// depends on iorr_pkg; bound to isotp_obd_response_reassembler below
module iorr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              frame_valid,
    input logic              frame_stall,
    input logic              result_valid,
    input logic              result_stall,
    input iorr_pkg::result_t result
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // one frame in work at a time
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("frame taken while previous frame in work");

    // flow control is a single beat with zero message length and byte index
    a_fc_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == iorr_pkg::KIND_FLOW) |->
            result.last && (result.msg_length == 7'd0) && (result.byte_index == 6'd0))
        else $error("malformed flow control beat");

    // beats of one run follow without gaps
    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid)
        else $error("gap inside a message run");

endmodule

bind isotp_obd_response_reassembler iorr_checker u_iorr_checker (.*);

>>> verif/iorr_reassembly_checker.sv
// iorr_reassembly_checker: watches the frame and result channels of the reassembler,
// predicts every result beat from accepted frames and compares field by field
// depends on iorr_pkg for the frame and result beat types and protocol constants
module iorr_reassembly_checker #(
    parameter int CHANNELS  = 8,
    parameter int MSG_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    input  logic              frame_stall,
    input  iorr_pkg::frame_t  frame,
    input  logic              result_valid,
    input  logic              result_stall,
    input  iorr_pkg::result_t result,
    output int                fail_count,
    output int                outstanding
);

    logic       ch_open  [CHANNELS];
    logic [10:0] ch_tag  [CHANNELS];
    logic [3:0] ch_seq   [CHANNELS];
    int         ch_total [CHANNELS];
    int         ch_count [CHANNELS];
    logic [4:0] ch_mode  [CHANNELS];
    logic [7:0] ch_pid   [CHANNELS];
    logic [7:0] ch_bytes [CHANNELS][MSG_BYTES];

    iorr_pkg::result_t expected_results[$];
    int      mismatches = 0;
    int      pending_n = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending_n;

    function automatic iorr_pkg::result_t make_result(logic kind, logic [10:0] tid,
                                                      logic [5:0] mode, logic [7:0] pid,
                                                      logic [7:0] data, int idx,
                                                      int len, logic last);
        iorr_pkg::result_t r;
        r.kind       = kind;
        r.target_id  = tid;
        r.mode       = mode;
        r.pid        = pid;
        r.data_byte  = data;
        r.byte_index = 6'(idx);
        r.msg_length = 7'(len);
        r.last       = last;
        return r;
    endfunction

    task automatic reassemble_frame(input iorr_pkg::frame_t f);
        logic [7:0] b [8];
        logic [5:0] sf_mode;
        int ch;
        int n;
        int raw;
        int plen;
        b[0] = f.byte0;
        b[1] = f.byte1;
        b[2] = f.byte2;
        b[3] = f.byte3;
        b[4] = f.byte4;
        b[5] = f.byte5;
        b[6] = f.byte6;
        b[7] = f.byte7;
        if (f.can_id[10:8] != iorr_pkg::OBD_ID_HI)
            return;
        ch = f.can_id % CHANNELS;
        case (b[0][7:4])
            iorr_pkg::FT_SINGLE:
            begin
                // only frames with the response bit carry a message
                if (!b[1][6])
                    return;
                sf_mode = b[1][5:0];
                n = (int'(b[0][2:0]) > int'(iorr_pkg::SF_HDR))
                    ? int'(b[0][2:0]) - int'(iorr_pkg::SF_HDR) : 0;
                if (n == 0)
                    expected_results.push_back(make_result(iorr_pkg::KIND_MSG, f.can_id,
                                                           sf_mode, b[2], 8'h00, 0, 0,
                                                           1'b1));
                for (int j = 0; j < n; j++)
                    expected_results.push_back(make_result(iorr_pkg::KIND_MSG, f.can_id,
                                                           sf_mode, b[2], b[3 + j], j, n,
                                                           j == n - 1));
            end
            iorr_pkg::FT_FIRST:
            begin
                raw  = {b[0][3:0], b[1]};
                plen = raw - int'(iorr_pkg::HDR_BYTES);
                if (plen < 5 || plen > MSG_BYTES)
                    return;
                ch_open[ch]  = 1'b1;
                ch_tag[ch]   = f.can_id;
                ch_seq[ch]   = iorr_pkg::SEQ_FIRST;
                ch_total[ch] = plen;
                ch_count[ch] = iorr_pkg::FF_BYTES;
                ch_mode[ch]  = b[2][4:0];
                ch_pid[ch]   = b[3];
                for (int j = 0; j < iorr_pkg::FF_BYTES; j++)
                    ch_bytes[ch][j] = b[4 + j];
                expected_results.push_back(make_result(iorr_pkg::KIND_FLOW,
                                                       f.can_id - iorr_pkg::FC_ID_OFFSET,
                                                       6'h00, 8'h00, 8'h00, 0, 0, 1'b1));
            end
            iorr_pkg::FT_CONSEC:
            begin
                if (!ch_open[ch] || ch_tag[ch] != f.can_id)
                    return;
                if (ch_seq[ch] != b[0][3:0])
                    return;
                ch_seq[ch] = ch_seq[ch] + 4'd1;
                n = ch_total[ch] - ch_count[ch];
                if (n > int'(iorr_pkg::CF_BYTES))
                    n = int'(iorr_pkg::CF_BYTES);
                for (int j = 0; j < n; j++)
                    ch_bytes[ch][ch_count[ch] + j] = b[1 + j];
                ch_count[ch] = ch_count[ch] + n;
                if (ch_count[ch] != ch_total[ch])
                    return;
                for (int j = 0; j < ch_total[ch]; j++)
                    expected_results.push_back(make_result(iorr_pkg::KIND_MSG, f.can_id,
                                                           {1'b0, ch_mode[ch]}, ch_pid[ch],
                                                           ch_bytes[ch][j], j, ch_total[ch],
                                                           j == ch_total[ch] - 1));
                ch_open[ch] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [10:0] want_v,
                                 input logic [10:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: result %s mismatch, expected %0h actual %0h",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        iorr_pkg::result_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
                ch_open[c] = 1'b0;
            expected_results.delete();
            pending_n = 0;
        end
        else
        begin
            // result beats never come from a frame taken at the same edge
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none actual %p",
                             $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("kind", want.kind, result.kind);
                    compare_field("target_id", want.target_id, result.target_id);
                    compare_field("mode", want.mode, result.mode);
                    compare_field("pid", want.pid, result.pid);
                    compare_field("data_byte", want.data_byte, result.data_byte);
                    compare_field("byte_index", want.byte_index, result.byte_index);
                    compare_field("msg_length", want.msg_length, result.msg_length);
                    compare_field("last", want.last, result.last);
                end
            end
            if (frame_valid && !frame_stall)
                reassemble_frame(frame);
            pending_n = expected_results.size();
        end
    end

endmodule

>>> verif/tb_isotp_obd_response_reassembler.sv
// tb_isotp_obd_response_reassembler: drives directed and random can frames into the
// reassembler with random idling on both channels and reports the verdict
// depends on iorr_pkg, isotp_obd_response_reassembler and iorr_reassembly_checker
module tb_isotp_obd_response_reassembler;

    localparam int         RANDOM_ITEMS   = 60;
    localparam int         QUIET_ITEMS    = 20;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         TAIL_CYCLES    = 120;
    localparam int         SLOTS          = 4;
    localparam logic [3:0] FT_FLOW        = 4'h3;
    localparam logic [3:0] FT_RESERVED    = 4'hF;

    logic              clk;
    logic              rst_n;
    logic              frame_valid;
    logic              frame_stall;
    iorr_pkg::frame_t  frame_beat;
    logic              result_valid;
    logic              result_stall;
    iorr_pkg::result_t result_beat;
    int                fail_count;
    int                outstanding;
    logic              quiet = 1'b0;
    logic              frame_fire = 1'b0;
    int                idle_cycles = 0;

    isotp_obd_response_reassembler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat)
    );

    iorr_reassembly_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // acceptance seen at the rising edge, read back by the driver at the falling edge
    always @(posedge clk)
    begin
        frame_fire <= frame_valid && !frame_stall;
        if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        bit calm;
        calm = 1'b0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                calm = ~calm;
            if (!quiet && !calm && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic logic [55:0] rand_bytes();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[55:0];
    endfunction

    function automatic iorr_pkg::frame_t mk(logic [10:0] id, logic [3:0] ftype,
                                            logic [3:0] low, logic [55:0] rest);
        return {id, ftype, low, rest};
    endfunction

    function automatic logic [10:0] window_id();
        return {iorr_pkg::OBD_ID_HI, 8'($urandom)};
    endfunction

    // holds the beat until taken, then maybe leaves a gap
    task automatic send_frame(input iorr_pkg::frame_t f);
        frame_beat  <= f;
        frame_valid <= 1'b1;
        do
            @(negedge clk);
        while (!frame_fire);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        frame_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        iorr_pkg::frame_t f;
        logic [10:0] slot_id   [SLOTS];
        int          slot_left [SLOTS];
        logic [3:0]  slot_seq  [SLOTS];
        logic [11:0] raw;
        logic [55:0] rb;
        int          counted;
        int          s;
        int          pick;
        int          len;
        bit          paused;

        rst_n       = 1'b0;
        frame_valid = 1'b0;
        frame_beat  = '0;
        counted     = 0;
        paused      = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_left[i] = 0;
            slot_id[i]   = {iorr_pkg::OBD_ID_HI, 5'd0, 2'(i), 1'b0};
            slot_seq[i]  = iorr_pkg::SEQ_FIRST;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single full, empty, ignored length bit, no response bit; frames outside window
        send_frame(mk(11'h7E8, iorr_pkg::FT_SINGLE, 4'h7, 56'h41_0C_1A_F8_00_FF_55));
        send_frame(mk(11'h7FF, iorr_pkg::FT_SINGLE, 4'h2, 56'hC0_00_11_22_33_44_55));
        send_frame(mk(11'h700, iorr_pkg::FT_SINGLE, 4'h0, 56'h40_FF_11_22_33_44_55));
        send_frame(mk(11'h7E8, iorr_pkg::FT_SINGLE, 4'hF, 56'hFF_FF_80_01_02_03_04));
        send_frame(mk(11'h7E8, iorr_pkg::FT_SINGLE, 4'h7, 56'h01_0C_11_22_33_44_55));
        send_frame(mk(11'h6FF, iorr_pkg::FT_SINGLE, 4'h7, 56'h41_0C_11_22_33_44_55));
        send_frame(mk(11'h000, iorr_pkg::FT_FIRST, 4'h0, 56'h07_41_0C_01_02_03_04));

        // shortest segmented message, flow control wraps below the window
        send_frame(mk(11'h700, iorr_pkg::FT_FIRST, 4'h0, 56'h07_FF_FF_01_02_03_04));
        send_frame(mk(11'h708, iorr_pkg::FT_CONSEC, 4'h1, 56'hAA_AA_AA_AA_AA_AA_AA));
        send_frame(mk(11'h700, iorr_pkg::FT_CONSEC, 4'h2, 56'hBB_BB_BB_BB_BB_BB_BB));
        send_frame(mk(11'h700, iorr_pkg::FT_CONSEC, 4'h1, 56'h05_EE_EE_EE_EE_EE_EE));
        send_frame(mk(11'h700, iorr_pkg::FT_CONSEC, 4'h2, 56'hCC_CC_CC_CC_CC_CC_CC));

        // first frame length out of range
        send_frame(mk(11'h7FF, iorr_pkg::FT_FIRST, 4'h0, 56'h06_41_0C_01_02_03_04));
        send_frame(mk(11'h7FF, iorr_pkg::FT_FIRST, 4'h0, 56'h00_41_0C_01_02_03_04));
        send_frame(mk(11'h7FF, iorr_pkg::FT_FIRST, 4'h0, 56'h43_41_0C_01_02_03_04));
        send_frame(mk(11'h7FF, iorr_pkg::FT_FIRST, 4'hF, 56'hFF_41_0C_01_02_03_04));

        // a second first frame on the same channel replaces the entry
        send_frame(mk(11'h7FF, iorr_pkg::FT_FIRST, 4'h0, 56'h0A_21_0D_01_02_03_04));
        send_frame(mk(11'h7F7, iorr_pkg::FT_FIRST, 4'h0, 56'h0A_22_0E_05_06_07_08));
        send_frame(mk(11'h7F7, iorr_pkg::FT_CONSEC, 4'h1, 56'h09_0A_0B_0C_0D_0E_0F));

        send_frame(mk(11'h7E8, FT_FLOW, 4'h0, 56'h00_0A_00_00_00_00_00));
        send_frame(mk(11'h7E8, FT_RESERVED, 4'hF, 56'hFF_FF_FF_FF_FF_FF_FF));

        // longest message
        rb = rand_bytes();
        send_frame(mk(11'h7E9, iorr_pkg::FT_FIRST, 4'h0, {16'h42_3F, rb[39:8], 8'h00}));
        for (int i = 1; i <= 9; i++)
            send_frame(mk(11'h7E9, iorr_pkg::FT_CONSEC, 4'(i), rand_bytes()));
        wait_drained();

        // mostly well-formed interleaved messages, one channel pair per slot
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == RANDOM_ITEMS / 2 && !paused)
            begin
                wait_drained();
                paused = 1'b1;
            end
            quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
            s = $urandom_range(0, SLOTS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if (slot_left[s] <= 0)
                begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 64)
                                                      : $urandom_range(5, 20);
                    raw = 12'(len + 2);
                    slot_id[s] = {iorr_pkg::OBD_ID_HI, 5'($urandom), 2'(s), 1'($urandom)};
                    f = mk(slot_id[s], iorr_pkg::FT_FIRST, raw[11:8], rand_bytes());
                    f.byte1 = raw[7:0];
                    send_frame(f);
                    slot_left[s] = len - iorr_pkg::FF_BYTES;
                    slot_seq[s]  = iorr_pkg::SEQ_FIRST;
                end
                else
                begin
                    send_frame(mk(slot_id[s], iorr_pkg::FT_CONSEC, slot_seq[s],
                                  rand_bytes()));
                    slot_seq[s]  = slot_seq[s] + 4'd1;
                    slot_left[s] = slot_left[s] - int'(iorr_pkg::CF_BYTES);
                end
                counted++;
            end
            else if (pick < 85)
            begin
                f = mk(window_id(), iorr_pkg::FT_SINGLE, 4'($urandom), rand_bytes());
                f.byte1[6] = 1'b1;
                send_frame(f);
                counted++;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: f = mk(11'($urandom), 4'($urandom), 4'($urandom), rand_bytes());
                    1: f = mk(slot_id[s], iorr_pkg::FT_CONSEC,
                              slot_seq[s] + 4'($urandom_range(1, 15)), rand_bytes());
                    2: f = mk(slot_id[s] ^ 11'h008, iorr_pkg::FT_CONSEC, slot_seq[s],
                              rand_bytes());
                    3:
                    begin
                        raw = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 6))
                                                          : 12'($urandom_range(67, 4095));
                        f = mk(window_id(), iorr_pkg::FT_FIRST, raw[11:8], rand_bytes());
                        f.byte1 = raw[7:0];
                    end
                    4: f = mk(window_id(), 4'($urandom_range(3, 15)), 4'($urandom),
                              rand_bytes());
                    default:
                    begin
                        f = mk(window_id(), iorr_pkg::FT_SINGLE, 4'($urandom), rand_bytes());
                        f.byte1[6] = 1'b0;
                    end
                endcase
                send_frame(f);
            end
        end

        quiet = 1'b1;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
